>>> hw/rtl/tmhm_pkg.sv
package tmhm_pkg;

	localparam int unsigned HEAP_DEPTH_DEF = 16;
	localparam int unsigned KEY_W = 16;
	localparam int unsigned MOD_W = 17;
	localparam logic [MOD_W-1:0] MOD_RESET = 17'd65536;
	localparam logic [MOD_W-1:0] MOD_MIN = 17'd2;
	localparam logic [MOD_W-1:0] MOD_MAX = 17'd65536;

	localparam logic CMD_ARM = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic KIND_ARM = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic command;
		logic [7:0] timer_id;
		logic [7:0] owner_task;
		logic [15:0] delay;
	} in_t;

	typedef struct packed {
		logic reply_kind;
		logic [1:0] status;
		logic expired;
		logic [7:0] expired_id;
		logic [7:0] expired_owner;
		logic wake_task;
		logic reschedule;
		logic [15:0] tick_now;
		logic last;
	} out_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [7:0] id;
		logic [7:0] owner;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic is_tick;
		logic zero_delay;
		logic [7:0] timer_id;
		logic [7:0] owner_task;
		logic [15:0] delay;
	} cmd_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ARM_SUM,
		S_ARM_WRAP,
		S_ARM_PLACE,
		S_UP_CHK,
		S_UP_CMP,
		S_ARM_REPLY,
		S_TICK_START,
		S_TICK_CHK,
		S_TICK_ROOT,
		S_TICK_TAIL,
		S_DN_CHK,
		S_DN_LEFT,
		S_DN_RIGHT,
		S_TICK_END
	} state_t;

endpackage

>>> hw/rtl/timer_min_heap_manager.sv
// Timer manager over two binary min-heaps (current and next counter period).
// Input channel in_valid/in_stall/in_data carries one command per transfer:
// arm a timer (id, owner, delay) or advance the tick counter by one.
// Output channel out_valid/out_stall/out_data returns one reply per arm and
// one report per expired timer per tick (or one empty report); last marks
// the final transfer of a command.
// cfg_we/cfg_data write the counter modulus; write only while idle.
// A two-entry command queue sits in front of the heap sequencer, so up to
// two commands are taken while the sequencer works or the output stalls.
// Arm: the sequencer sums counter and delay, handles the wrap, places the timer
// and sifts it up level by level; a zero delay or a full heap skips the climb.
// Tick: each expired timer is read at the root, replaced by the tail and sifted
// down; the heap RAM has one write port and one registered read port.
// Output stall holds the reply register and holds the sequencer where it must emit a transfer.
// Reset empties both heaps, zeroes the counter and sets the modulus to 65536.
module timer_min_heap_manager #(
	parameter int unsigned HEAP_DEPTH = tmhm_pkg::HEAP_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [tmhm_pkg::MOD_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  tmhm_pkg::in_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output tmhm_pkg::out_t out_data
);
	import tmhm_pkg::*;

	logic cmd_valid;
	logic cmd_take;
	cmd_t cmd;

	tmhm_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.cmd_valid(cmd_valid),
		.cmd_take(cmd_take),
		.cmd(cmd)
	);

	tmhm_back #(
		.HEAP_DEPTH(HEAP_DEPTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.cmd_valid(cmd_valid),
		.cmd_take(cmd_take),
		.cmd(cmd),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	a_status_arm_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |-> out_data.reply_kind == KIND_ARM)
		else $error("nonzero status on a tick report");

	a_wake_needs_expiry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.wake_task |-> out_data.expired && out_data.expired_owner != 8'd0)
		else $error("wake without expired task timer");

	a_resched_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.reschedule |-> out_data.last && out_data.reply_kind == KIND_TICK)
		else $error("reschedule outside last tick report");

endmodule

>>> hw/rtl/tmhm_ram.sv
module tmhm_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> hw/rtl/tmhm_front.sv
module tmhm_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  tmhm_pkg::in_t in_data,
	output logic cmd_valid,
	input  logic cmd_take,
	output tmhm_pkg::cmd_t cmd
);
	import tmhm_pkg::*;

	cmd_t fifo_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] fill_q;
	logic push;
	logic pop;
	cmd_t decoded;

	always_comb begin
		decoded.is_tick = (in_data.command == CMD_TICK);
		decoded.zero_delay = (in_data.delay == 16'd0);
		decoded.timer_id = in_data.timer_id;
		decoded.owner_task = in_data.owner_task;
		decoded.delay = in_data.delay;
	end

	assign in_stall = (fill_q == 2'd2);
	assign push = in_valid && !in_stall;
	assign cmd_valid = (fill_q != 2'd0);
	assign pop = cmd_valid && cmd_take;
	assign cmd = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= decoded;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) fill_q <= fill_q + 2'd1;
			else if (pop && !push) fill_q <= fill_q - 2'd1;
		end
	end
endmodule

>>> hw/rtl/tmhm_back.sv
module tmhm_back #(
	parameter int unsigned HEAP_DEPTH = tmhm_pkg::HEAP_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [tmhm_pkg::MOD_W-1:0] cfg_data,
	input  logic cmd_valid,
	output logic cmd_take,
	input  tmhm_pkg::cmd_t cmd,
	output logic out_valid,
	input  logic out_stall,
	output tmhm_pkg::out_t out_data
);
	import tmhm_pkg::*;

	localparam int unsigned IW = $clog2(HEAP_DEPTH + 1);
	localparam int unsigned AW = IW + 1;
	localparam int unsigned RAM_DEPTH = 2 << IW;
	localparam logic [IW-1:0] ROOT = IW'(1);
	localparam logic [IW-1:0] DEPTH_I = IW'(HEAP_DEPTH);

	state_t state_q, state_d;

	logic [MOD_W-1:0] mod_q;
	logic [MOD_W-1:0] modm1_q;
	logic [15:0] counter_q;
	logic cur_q;
	logic [IW-1:0] count_q [2];
	logic hsel_q;
	entry_t x_q;
	entry_t left_q;
	entry_t pend_q;
	logic pend_v_q;
	logic woke_q;
	logic at_end_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] n_q;
	logic [IW-1:0] cnt_q;
	logic [1:0] status_q;
	cmd_t cmd_q;
	logic [MOD_W-1:0] sum_q;
	logic [MOD_W-1:0] diff_q;
	logic wrap_q;
	out_t out_q;
	logic out_valid_q;

	logic out_free;
	logic [MOD_W-1:0] cfg_clamped;
	logic [MOD_W-1:0] nxt_raw;
	logic [15:0] nxt;
	logic [KEY_W-1:0] arm_key;
	logic arm_sel;
	logic arm_full;
	logic [IW:0] lchild;
	logic [IW:0] rchild;
	logic l_in;
	logic r_in;
	logic root_hit;
	logic tick_go;
	entry_t rdata;
	logic [ENTRY_W-1:0] rdata_raw;
	entry_t dn_c;
	logic [IW-1:0] dn_ci;
	logic dn_move;

	logic ram_we;
	logic [IW-1:0] ram_widx;
	entry_t ram_wdata;
	logic [IW-1:0] ram_ridx;

	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign rdata = entry_t'(rdata_raw);

	always_comb begin
		if (cfg_data < MOD_MIN) cfg_clamped = MOD_MIN;
		else if (cfg_data > MOD_MAX) cfg_clamped = MOD_MAX;
		else cfg_clamped = cfg_data;
	end

	assign nxt_raw = {1'b0, counter_q} + MOD_W'(1);
	assign nxt = (nxt_raw >= mod_q) ? 16'd0 : nxt_raw[15:0];

	always_comb begin
		arm_sel = cur_q;
		arm_key = sum_q[KEY_W-1:0];
		if (wrap_q) begin
			arm_sel = !cur_q;
			arm_key = (diff_q >= mod_q) ? modm1_q[KEY_W-1:0] : diff_q[KEY_W-1:0];
		end
		arm_full = (count_q[arm_sel] >= DEPTH_I);
	end

	assign lchild = {idx_q, 1'b0};
	assign rchild = {idx_q, 1'b1};
	assign l_in = (lchild <= {1'b0, n_q});
	assign r_in = (rchild <= {1'b0, n_q});
	assign root_hit = at_end_q || (rdata.key <= counter_q);
	assign tick_go = root_hit && (!pend_v_q || out_free);

	always_comb begin
		dn_c = rdata;
		dn_ci = lchild[IW-1:0];
		if (state_q == S_DN_RIGHT) begin
			if (rdata.key < left_q.key) begin
				dn_c = rdata;
				dn_ci = rchild[IW-1:0];
			end else begin
				dn_c = left_q;
				dn_ci = lchild[IW-1:0];
			end
		end
		dn_move = (dn_c.key < x_q.key);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					if (cmd.is_tick) state_d = S_TICK_START;
					else if (cmd.zero_delay) state_d = S_ARM_REPLY;
					else state_d = S_ARM_SUM;
				end
			end
			S_ARM_SUM: state_d = S_ARM_WRAP;
			S_ARM_WRAP: state_d = S_ARM_PLACE;
			S_ARM_PLACE: state_d = arm_full ? S_ARM_REPLY : S_UP_CHK;
			S_UP_CHK: state_d = (idx_q == ROOT) ? S_ARM_REPLY : S_UP_CMP;
			S_UP_CMP: state_d = (rdata.key > x_q.key) ? S_UP_CHK : S_ARM_REPLY;
			S_ARM_REPLY: if (out_free) state_d = S_IDLE;
			S_TICK_START: state_d = S_TICK_CHK;
			S_TICK_CHK: begin
				if (count_q[hsel_q] == '0 || cnt_q == DEPTH_I) state_d = S_TICK_END;
				else state_d = S_TICK_ROOT;
			end
			S_TICK_ROOT: begin
				if (!root_hit) state_d = S_TICK_END;
				else if (tick_go) state_d = S_TICK_TAIL;
			end
			S_TICK_TAIL: state_d = S_DN_CHK;
			S_DN_CHK: state_d = l_in ? S_DN_LEFT : S_TICK_CHK;
			S_DN_LEFT: begin
				if (r_in) state_d = S_DN_RIGHT;
				else state_d = dn_move ? S_DN_CHK : S_TICK_CHK;
			end
			S_DN_RIGHT: state_d = dn_move ? S_DN_CHK : S_TICK_CHK;
			S_TICK_END: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd_take = 1'b0;
		ram_we = 1'b0;
		ram_widx = idx_q;
		ram_wdata = x_q;
		ram_ridx = ROOT;
		unique case (state_q)
			S_IDLE: cmd_take = cmd_valid;
			S_UP_CHK: begin
				if (idx_q == ROOT) ram_we = 1'b1;
				else ram_ridx = idx_q >> 1;
			end
			S_UP_CMP: begin
				ram_we = 1'b1;
				if (rdata.key > x_q.key) ram_wdata = rdata;
			end
			S_TICK_ROOT: if (tick_go) ram_ridx = count_q[hsel_q];
			S_DN_CHK: begin
				if (l_in) ram_ridx = lchild[IW-1:0];
				else ram_we = 1'b1;
			end
			S_DN_LEFT: begin
				if (r_in) begin
					ram_ridx = rchild[IW-1:0];
				end else begin
					ram_we = 1'b1;
					if (dn_move) ram_wdata = dn_c;
				end
			end
			S_DN_RIGHT: begin
				ram_we = 1'b1;
				if (dn_move) ram_wdata = dn_c;
			end
			default: ;
		endcase
	end

	tmhm_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(RAM_DEPTH)
	) u_heap_ram (
		.clk(clk),
		.we(ram_we),
		.waddr({hsel_q, ram_widx}),
		.wdata(ram_wdata),
		.raddr({hsel_q, ram_ridx}),
		.rdata(rdata_raw)
	);

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (cmd_valid) cmd_q <= cmd;
			S_ARM_SUM: sum_q <= {1'b0, counter_q} + {1'b0, cmd_q.delay};
			S_ARM_WRAP: begin
				wrap_q <= (sum_q >= mod_q);
				diff_q <= sum_q - mod_q;
			end
			S_ARM_PLACE: begin
				idx_q <= count_q[arm_sel] + IW'(1);
				hsel_q <= arm_sel;
				x_q <= '{key: arm_key, id: cmd_q.timer_id, owner: cmd_q.owner_task};
			end
			S_UP_CMP: if (rdata.key > x_q.key) idx_q <= idx_q >> 1;
			S_TICK_START: hsel_q <= cur_q;
			S_TICK_ROOT: if (tick_go) pend_q <= rdata;
			S_TICK_TAIL: begin
				x_q <= rdata;
				n_q <= count_q[hsel_q] - IW'(1);
				idx_q <= ROOT;
			end
			S_DN_LEFT: begin
				left_q <= rdata;
				if (!r_in && dn_move) idx_q <= dn_ci;
			end
			S_DN_RIGHT: if (dn_move) idx_q <= dn_ci;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mod_q <= MOD_RESET;
			modm1_q <= MOD_RESET - MOD_W'(1);
			counter_q <= 16'd0;
			cur_q <= 1'b0;
			count_q[0] <= '0;
			count_q[1] <= '0;
			pend_v_q <= 1'b0;
			woke_q <= 1'b0;
			at_end_q <= 1'b0;
			cnt_q <= '0;
			status_q <= ST_OK;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				mod_q <= cfg_clamped;
				modm1_q <= cfg_clamped - MOD_W'(1);
			end
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						status_q <= cmd.zero_delay ? ST_ZERO : ST_OK;
						if (cmd.is_tick) counter_q <= nxt;
					end
				end
				S_ARM_PLACE: begin
					if (arm_full) status_q <= ST_FULL;
					else count_q[arm_sel] <= count_q[arm_sel] + IW'(1);
				end
				S_ARM_REPLY: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_q <= '{reply_kind: KIND_ARM, status: status_q,
							tick_now: counter_q, last: 1'b1, default: '0};
					end
				end
				S_TICK_START: begin
					at_end_q <= ({1'b0, counter_q} == modm1_q);
					cnt_q <= '0;
					woke_q <= 1'b0;
					pend_v_q <= 1'b0;
				end
				S_TICK_ROOT: begin
					if (tick_go) begin
						if (pend_v_q) begin
							out_valid_q <= 1'b1;
							out_q <= '{reply_kind: KIND_TICK, status: ST_OK, expired: 1'b1,
								expired_id: pend_q.id, expired_owner: pend_q.owner,
								wake_task: (pend_q.owner != 8'd0), reschedule: 1'b0,
								tick_now: counter_q, last: 1'b0};
						end
						pend_v_q <= 1'b1;
						if (rdata.owner != 8'd0) woke_q <= 1'b1;
						cnt_q <= cnt_q + IW'(1);
					end
				end
				S_TICK_TAIL: count_q[hsel_q] <= count_q[hsel_q] - IW'(1);
				S_TICK_END: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (pend_v_q) begin
							out_q <= '{reply_kind: KIND_TICK, status: ST_OK, expired: 1'b1,
								expired_id: pend_q.id, expired_owner: pend_q.owner,
								wake_task: (pend_q.owner != 8'd0), reschedule: woke_q,
								tick_now: counter_q, last: 1'b1};
						end else begin
							out_q <= '{reply_kind: KIND_TICK, status: ST_OK,
								tick_now: counter_q, last: 1'b1, default: '0};
						end
						if (at_end_q) cur_q <= !cur_q;
					end
				end
				default: ;
			endcase
		end
	end
endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
	import tmhm_pkg::*;

	localparam int DEPTH = 16;
	localparam int LIMIT = 600000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [MOD_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_t out_data;

	timer_min_heap_manager DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	in_t pending[$];
	out_t due_reports[$];
	int send_idle = 7;
	int recv_idle = 45;
	bit hold = 1'b0;
	bit took = 1'b0;
	int errors = 0;
	int cycles = 0;
	int n_cmds = 0;
	int n_reports = 0;
	int n_expired = 0;
	int n_full = 0;

	logic [MOD_W-1:0] modulus_reg = MOD_RESET;
	logic [15:0] counter = '0;
	entry_t heaps[2][1:DEPTH];
	int heap_len[2] = '{0, 0};
	bit cur_sel = 1'b0;

	function automatic int unsigned eff_modulus();
		if (modulus_reg < MOD_MIN) return MOD_MIN;
		if (modulus_reg > MOD_MAX) return MOD_MAX;
		return modulus_reg;
	endfunction

	function automatic void heap_up(bit s, int i);
		entry_t t;
		while (i > 1 && heaps[s][i >> 1].key > heaps[s][i].key) begin
			t = heaps[s][i >> 1];
			heaps[s][i >> 1] = heaps[s][i];
			heaps[s][i] = t;
			i = i >> 1;
		end
	endfunction

	function automatic void heap_down(bit s, int n);
		int i;
		int l;
		int c;
		entry_t t;
		i = 1;
		forever begin
			l = i << 1;
			if (l + 1 <= n && heaps[s][l + 1].key < heaps[s][l].key) c = l + 1;
			else c = l;
			if (c <= n && heaps[s][c].key < heaps[s][i].key) begin
				t = heaps[s][c];
				heaps[s][c] = heaps[s][i];
				heaps[s][i] = t;
				i = c;
			end else begin
				break;
			end
		end
	endfunction

	function automatic void predict_command(in_t cmd);
		int unsigned m;
		int unsigned key;
		int unsigned nxt;
		bit s;
		bit at_end;
		bit woke;
		int cnt;
		entry_t e;
		out_t r;
		m = eff_modulus();
		r = '0;
		if (cmd.command == CMD_ARM) begin
			r.reply_kind = KIND_ARM;
			r.status = ST_OK;
			if (cmd.delay == 0) begin
				r.status = ST_ZERO;
			end else begin
				key = counter + cmd.delay;
				s = cur_sel;
				if (key >= m) begin
					key = key - m;
					if (key >= m) key = m - 1;
					s = ~s;
				end
				if (heap_len[s] >= DEPTH) begin
					r.status = ST_FULL;
					n_full++;
				end else begin
					heap_len[s]++;
					heaps[s][heap_len[s]] = '{key: key[15:0], id: cmd.timer_id,
						owner: cmd.owner_task};
					heap_up(s, heap_len[s]);
				end
			end
			r.tick_now = counter;
			r.last = 1'b1;
			due_reports.push_back(r);
			return;
		end
		nxt = counter + 1;
		if (nxt >= m) nxt = 0;
		counter = nxt[15:0];
		at_end = (nxt == m - 1);
		s = cur_sel;
		cnt = 0;
		woke = 1'b0;
		while (heap_len[s] > 0 && (at_end || heaps[s][1].key <= nxt) && cnt < DEPTH) begin
			e = heaps[s][1];
			heaps[s][1] = heaps[s][heap_len[s]];
			heap_len[s]--;
			heap_down(s, heap_len[s]);
			if (e.owner != 0) woke = 1'b1;
			r = '0;
			r.reply_kind = KIND_TICK;
			r.expired = 1'b1;
			r.expired_id = e.id;
			r.expired_owner = e.owner;
			r.wake_task = (e.owner != 0);
			r.tick_now = counter;
			due_reports.push_back(r);
			cnt++;
			n_expired++;
		end
		if (at_end) cur_sel = ~cur_sel;
		if (cnt == 0) begin
			r = '0;
			r.reply_kind = KIND_TICK;
			r.tick_now = counter;
			r.last = 1'b1;
			due_reports.push_back(r);
		end else begin
			due_reports[$].reschedule = woke;
			due_reports[$].last = 1'b1;
		end
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
		if (in_valid && !in_stall) begin
			predict_command(in_data);
			void'(pending.pop_front());
			took = 1'b1;
			n_cmds++;
		end
		if (out_valid && !out_stall) begin
			n_reports++;
			if (due_reports.size() == 0) begin
				$error("unexpected transfer on output");
				errors++;
			end else begin
				check_field("reply_kind", 16'(due_reports[0].reply_kind),
					16'(out_data.reply_kind));
				check_field("status", 16'(due_reports[0].status), 16'(out_data.status));
				check_field("expired", 16'(due_reports[0].expired), 16'(out_data.expired));
				check_field("expired_id", 16'(due_reports[0].expired_id),
					16'(out_data.expired_id));
				check_field("expired_owner", 16'(due_reports[0].expired_owner),
					16'(out_data.expired_owner));
				check_field("wake_task", 16'(due_reports[0].wake_task),
					16'(out_data.wake_task));
				check_field("reschedule", 16'(due_reports[0].reschedule),
					16'(out_data.reschedule));
				check_field("tick_now", due_reports[0].tick_now, out_data.tick_now);
				check_field("last", 16'(due_reports[0].last), 16'(out_data.last));
				void'(due_reports.pop_front());
			end
		end
	end

	always @(negedge clk) begin
		if (!(in_valid && !took)) begin
			if (pending.size() > 0 && !hold && arst_n
					&& $urandom_range(99) >= send_idle) begin
				in_valid <= 1'b1;
				in_data <= pending[0];
			end else begin
				in_valid <= 1'b0;
			end
		end
		took = 1'b0;
		out_stall <= ($urandom_range(99) < recv_idle);
	end

	function automatic in_t arm(int id, int own, int dly);
		in_t c;
		c.command = CMD_ARM;
		c.timer_id = id[7:0];
		c.owner_task = own[7:0];
		c.delay = dly[15:0];
		return c;
	endfunction

	function automatic in_t tick();
		in_t c;
		c.command = CMD_TICK;
		c.timer_id = 8'($urandom);
		c.owner_task = 8'($urandom);
		c.delay = 16'($urandom);
		return c;
	endfunction

	task automatic settle();
		wait (pending.size() == 0 && due_reports.size() == 0);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_modulus(logic [MOD_W-1:0] v);
		settle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		modulus_reg = v;
	endtask

	task automatic random_run(int count);
		int unsigned m;
		int own;
		int dly;
		m = eff_modulus();
		repeat (count) begin
			if ($urandom_range(99) < 45) begin
				own = ($urandom_range(3) == 0) ? 0 : $urandom_range(255);
				case ($urandom_range(9))
					0: dly = 0;
					1, 2, 3: dly = $urandom_range(65535);
					default: dly = $urandom_range(1, (2 * m > 65535) ? 65535 : 2 * m);
				endcase
				pending.push_back(arm($urandom_range(255), own, dly));
			end else begin
				pending.push_back(tick());
			end
		end
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		pending.push_back(arm(0, 0, 0));
		pending.push_back(arm(255, 255, 1));
		pending.push_back(arm(0, 0, 2));
		pending.push_back(arm(170, 85, 65535));
		pending.push_back(arm(85, 170, 65535));
		repeat (3) pending.push_back(tick());

		write_modulus(17'd0);
		pending.push_back(arm(1, 7, 1));
		pending.push_back(arm(2, 0, 3));
		pending.push_back(arm(3, 9, 65535));
		repeat (4) pending.push_back(tick());

		write_modulus(17'd5);
		for (int k = 0; k < 17; k++) pending.push_back(arm(k + 16, k & 1, 2));
		repeat (6) pending.push_back(tick());

		wait (pending.size() <= 3);
		hold = 1'b1;
		wait (due_reports.size() == 0);
		hold = 1'b0;

		write_modulus(17'd7);
		random_run(24);
		write_modulus(17'h1FFFF);
		random_run(24);
		send_idle = 45;
		recv_idle = 7;
		write_modulus(17'd13);
		random_run(24);
		write_modulus(17'd1);
		random_run(24);
		send_idle = 0;
		recv_idle = 0;
		write_modulus(17'd65536);
		random_run(12);
		write_modulus(17'd100);
		random_run(12);

		settle();
		$display("Covered %0d commands and %0d reports: %0d expiries, %0d full-heap refusals,",
			n_cmds, n_reports, n_expired, n_full);
		$display("moduli from below the minimum to above the maximum, with and without stalls.");
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
